// ----- rtl/tea_pkg.sv -----
// Shared types and constants for the TEA block cipher pipeline.
package tea_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned CFG_INDEX_W = 8;

  typedef logic [WORD_W-1:0]                 word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0]  key_t;
  typedef logic [CFG_INDEX_W-1:0]            cfg_index_t;

  localparam word_t TEA_DELTA = 32'h9E37_79B9;

  // Register indexes on the configuration channel
  localparam cfg_index_t REG_KEY0 = 8'd0;
  localparam cfg_index_t REG_KEY1 = 8'd1;
  localparam cfg_index_t REG_KEY2 = 8'd2;
  localparam cfg_index_t REG_KEY3 = 8'd3;

  localparam word_t KEY0_RESET = 32'hBCDE_AAAA;
  localparam word_t KEY1_RESET = 32'h87FB_BBBA;
  localparam word_t KEY2_RESET = 32'h7CCC_CFFA;
  localparam word_t KEY3_RESET = 32'hDDDD_AABC;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // One pipeline slot: valid bit plus the block in flight
  typedef struct packed {
    logic  valid;
    logic  op;
    logic  last;
    word_t v0;
    word_t v1;
  } stage_t;

endpackage

// ----- rtl/tea_key_regs.sv -----
// Key register file written through the configuration channel.
module tea_key_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  tea_pkg::cfg_index_t cfg_index,
  input  tea_pkg::word_t      cfg_data,
  output tea_pkg::key_t       key
);
  import tea_pkg::*;

  logic wr;

  assign wr = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= KEY0_RESET;
      key[1] <= KEY1_RESET;
      key[2] <= KEY2_RESET;
      key[3] <= KEY3_RESET;
    end else if (wr) begin
      case (cfg_index)
        REG_KEY0: key[0] <= cfg_data;
        REG_KEY1: key[1] <= cfg_data;
        REG_KEY2: key[2] <= cfg_data;
        REG_KEY3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    !wr |=> $stable(key))
    else $error("key changed without a config transaction");

  a_key0_write: assert property (@(posedge clk) disable iff (rst)
    (wr && cfg_index == REG_KEY0) |=> key[0] == $past(cfg_data))
    else $error("key word 0 write lost");
`endif

endmodule

// ----- rtl/tea_half_round.sv -----
// One registered TEA half-round, direction chosen per item.
module tea_half_round #(
  parameter logic [31:0] ENC_SUM  = 32'h0,
  parameter logic [31:0] DEC_SUM  = 32'h0,
  parameter bit          ODD_HALF = 1'b0
) (
  input  logic            clk,
  input  logic            rst,
  input  tea_pkg::key_t   key,
  input  tea_pkg::stage_t din,
  output tea_pkg::stage_t dout
);
  import tea_pkg::*;

  logic  src_v1;
  word_t src;
  word_t dst;
  word_t kl;
  word_t kr;
  word_t sum;
  word_t mix;
  word_t dst_new;
  logic  valid;
  logic  op;
  logic  last;
  word_t v0;
  word_t v1;

  // encrypt even / decrypt odd halves update v0 from v1
  assign src_v1  = (din.op == OP_ENCRYPT) ^ ODD_HALF;
  assign src     = src_v1 ? din.v1 : din.v0;
  assign dst     = src_v1 ? din.v0 : din.v1;
  assign kl      = src_v1 ? key[0] : key[2];
  assign kr      = src_v1 ? key[1] : key[3];
  assign sum     = (din.op == OP_DECRYPT) ? DEC_SUM : ENC_SUM;
  assign mix     = ((src << 4) + kl) ^ (src + sum) ^ ((src >> 5) + kr);
  assign dst_new = (din.op == OP_ENCRYPT) ? dst + mix : dst - mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    op   <= din.op;
    last <= din.last;
    v0   <= src_v1 ? dst_new : din.v0;
    v1   <= src_v1 ? din.v1 : dst_new;
  end

  assign dout = '{valid: valid, op: op, last: last, v0: v0, v1: v1};

endmodule

// ----- rtl/tea_block_cipher.sv -----
// TEA block cipher: key registers and a fully pipelined half-round chain.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   command  | start / busy           | operation, first_word, second_word,
//            |                        | last_block
//   result   | done (strobe)          | result_first, result_second, result_last
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One block can enter every cycle while busy is low; each result passes through one register
// stage per half-round (64 stages at 32 rounds).
// busy is high only while rst is asserted; cfg_ready is always high.
// rst clears every stage valid bit and loads the default key.
// The result strobe cannot be held off, so the pipeline never stalls.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                operation,
  input  tea_pkg::word_t      first_word,
  input  tea_pkg::word_t      second_word,
  input  logic                last_block,
  output logic                done,
  output tea_pkg::word_t      result_first,
  output tea_pkg::word_t      result_second,
  output logic                result_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  tea_pkg::cfg_index_t cfg_index,
  input  tea_pkg::word_t      cfg_data
);
  import tea_pkg::*;

  localparam int unsigned HALVES = 2 * ROUNDS;

  key_t   key;
  stage_t pipe [0:HALVES];

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  tea_key_regs u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign pipe[0] = '{valid: start & ~busy, op: operation, last: last_block,
                     v0: first_word, v1: second_word};

  for (genvar h = 0; h < HALVES; h++) begin : g_half
    localparam logic [31:0] ENC_SUM = 32'(TEA_DELTA * 32'(h / 2 + 1));
    localparam logic [31:0] DEC_SUM = 32'(TEA_DELTA * 32'(ROUNDS - h / 2));

    tea_half_round #(
      .ENC_SUM  (ENC_SUM),
      .DEC_SUM  (DEC_SUM),
      .ODD_HALF (1'(h % 2))
    ) u_half (
      .clk  (clk),
      .rst  (rst),
      .key  (key),
      .din  (pipe[h]),
      .dout (pipe[h+1])
    );
  end

  assign done          = pipe[HALVES].valid;
  assign result_first  = pipe[HALVES].v0;
  assign result_second = pipe[HALVES].v1;
  assign result_last   = pipe[HALVES].last;

`ifndef SYNTHESIS
  a_no_done_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");
`endif

endmodule

// ----- sim/tb_tea_block_cipher.sv -----
// Self-checking testbench for the TEA block cipher pipeline: key writes, encrypt/decrypt traffic.
`timescale 1ns / 100ps

module tb_tea_block_cipher;
  import tea_pkg::*;

  localparam int unsigned CIPHER_ROUNDS = 32;
  localparam int unsigned PIPE_LATENCY  = 2 * CIPHER_ROUNDS;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  // Indexes past the key registers; writes there must leave the key alone
  localparam cfg_index_t UNMAPPED_REG_LO = REG_KEY3 + 8'd1;
  localparam cfg_index_t UNMAPPED_REG_HI = '1;

  typedef struct packed {
    word_t first;
    word_t second;
    logic  last;
  } cipher_result_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       operation;
  word_t      first_word;
  word_t      second_word;
  logic       last_block;
  logic       done;
  word_t      result_first;
  word_t      result_second;
  logic       result_last;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  word_t      cfg_data;

  word_t          key_model [KEY_WORDS];
  cipher_result_t expected_blocks [$];
  int unsigned    fail_count;
  int unsigned    cycle_count;

  tea_block_cipher #(.ROUNDS(CIPHER_ROUNDS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .first_word   (first_word),
    .second_word  (second_word),
    .last_block   (last_block),
    .done         (done),
    .result_first (result_first),
    .result_second(result_second),
    .result_last  (result_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t tea_mix(word_t w, word_t sum, word_t kl, word_t kr);
    return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
  endfunction

  function automatic cipher_result_t tea_compute(logic op, word_t a, word_t b, logic last);
    cipher_result_t res;
    word_t          v0;
    word_t          v1;
    word_t          sum;
    v0 = a;
    v1 = b;
    if (op == OP_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < CIPHER_ROUNDS; r++) begin
        sum = sum + TEA_DELTA;
        v0  = v0 + tea_mix(v1, sum, key_model[REG_KEY0], key_model[REG_KEY1]);
        v1  = v1 + tea_mix(v0, sum, key_model[REG_KEY2], key_model[REG_KEY3]);
      end
    end else begin
      sum = word_t'(TEA_DELTA * CIPHER_ROUNDS);
      for (int r = 0; r < CIPHER_ROUNDS; r++) begin
        v1  = v1 - tea_mix(v0, sum, key_model[REG_KEY2], key_model[REG_KEY3]);
        v0  = v0 - tea_mix(v1, sum, key_model[REG_KEY0], key_model[REG_KEY1]);
        sum = sum - TEA_DELTA;
      end
    end
    res.first  = v0;
    res.second = v1;
    res.last   = last;
    return res;
  endfunction

  // Result checker: every strobe must match the oldest outstanding block
  always @(posedge clk) begin
    cipher_result_t exp_res;
    if (!rst && done) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result first=%h second=%h last=%b",
                 $time, result_first, result_second, result_last);
        fail_count++;
      end else begin
        exp_res = expected_blocks.pop_front();
        if (result_first !== exp_res.first) begin
          $display("%0t: result_first mismatch expected=%h actual=%h",
                   $time, exp_res.first, result_first);
          fail_count++;
        end
        if (result_second !== exp_res.second) begin
          $display("%0t: result_second mismatch expected=%h actual=%h",
                   $time, exp_res.second, result_second);
          fail_count++;
        end
        if (result_last !== exp_res.last) begin
          $display("%0t: result_last mismatch expected=%b actual=%b",
                   $time, exp_res.last, result_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_blocks.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One command transaction; start stays high so back-to-back calls issue every cycle while busy is low
  task automatic send_block(input logic op, input word_t a, input word_t b, input logic last);
    @(negedge clk);
    start       <= 1'b1;
    operation   <= op;
    first_word  <= a;
    second_word <= b;
    last_block  <= last;
    do @(posedge clk); while (busy);
    expected_blocks.push_back(tea_compute(op, a, b, last));
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_drain();
    idle_cycle();
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input word_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY0: key_model[REG_KEY0] = data;
      REG_KEY1: key_model[REG_KEY1] = data;
      REG_KEY2: key_model[REG_KEY2] = data;
      REG_KEY3: key_model[REG_KEY3] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
    wait_drain();
    write_register(REG_KEY0, k0);
    write_register(REG_KEY1, k1);
    write_register(REG_KEY2, k2);
    write_register(REG_KEY3, k3);
  endtask

  // Extreme blocks in both directions, last flag both ways
  task automatic send_edge_blocks();
    send_block(OP_ENCRYPT, '0, '0, 1'b0);
    send_block(OP_ENCRYPT, '1, '1, 1'b1);
    send_block(OP_DECRYPT, '0, '0, 1'b1);
    send_block(OP_DECRYPT, '1, '1, 1'b0);
    send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1);
  endtask

  task automatic test_default_key();
    cipher_result_t ct;
    send_edge_blocks();
    ct = tea_compute(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, 1'b0);
    send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, 1'b0);
    send_block(OP_DECRYPT, ct.first, ct.second, 1'b1);
  endtask

  task automatic test_unmapped_register();
    wait_drain();
    write_register(UNMAPPED_REG_LO, $urandom);
    write_register(UNMAPPED_REG_HI, '1);
    write_register(cfg_index_t'($urandom_range(UNMAPPED_REG_HI, UNMAPPED_REG_LO)), $urandom);
    send_block(OP_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_block(OP_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
  endtask

  task automatic test_key_extremes();
    set_key('0, '0, '0, '0);
    send_edge_blocks();
    set_key('1, '1, '1, '1);
    send_edge_blocks();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count,
                                     input bit with_pause);
    cipher_result_t ct;
    word_t          a;
    word_t          b;
    word_t          k [KEY_WORDS];
    logic           last;
    int unsigned    kind;
    // Mostly random key words, occasionally pinned to an extreme
    for (int i = 0; i < KEY_WORDS; i++) begin
      case ($urandom_range(5))
        0:       k[i] = '0;
        1:       k[i] = '1;
        default: k[i] = $urandom;
      endcase
    end
    set_key(k[0], k[1], k[2], k[3]);
    for (int i = 0; i < count; i++) begin
      if (with_pause && i == count / 2) wait_drain();
      while ($urandom_range(99) < idle_pct) idle_cycle();
      a    = $urandom;
      b    = $urandom;
      last = ($urandom_range(7) == 0);
      kind = $urandom_range(9);
      if (kind < 3) begin
        // round trip: decrypt a block that this key just encrypted
        ct = tea_compute(OP_ENCRYPT, a, b, last);
        send_block(OP_DECRYPT, ct.first, ct.second, last);
      end else if (kind < 7) begin
        send_block(OP_ENCRYPT, a, b, last);
      end else begin
        send_block(OP_DECRYPT, a, b, last);
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    operation   = OP_ENCRYPT;
    first_word  = '0;
    second_word = '0;
    last_block  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_KEY0;
    cfg_data    = '0;
    fail_count  = 0;
    cycle_count = 0;
    key_model[REG_KEY0] = KEY0_RESET;
    key_model[REG_KEY1] = KEY1_RESET;
    key_model[REG_KEY2] = KEY2_RESET;
    key_model[REG_KEY3] = KEY3_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_key();
    test_unmapped_register();
    test_key_extremes();
    test_random_traffic(32, 330, 1'b1);
    test_random_traffic(83, 330, 1'b0);
    test_random_traffic(0, 340, 1'b1);

    wait_drain();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- tea_block_cipher.f -----
rtl/tea_pkg.sv
rtl/tea_key_regs.sv
rtl/tea_half_round.sv
rtl/tea_block_cipher.sv
sim/tb_tea_block_cipher.sv
